>>> hdl/ide_task_file_controller_defines.svh
// Assertion macros shared by the task file checker.
`ifndef IDE_TASK_FILE_CONTROLLER_DEFINES_SVH
`define IDE_TASK_FILE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define IDE_TF_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IDE_TF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Delayed implication: the consequent is checked after the antecedent.
`define IDE_TF_ASSERT_LAT2(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

>>> hdl/ide_tf_pkg.sv
// Types, codes and constants of the IDE task file controller.
package ide_tf_pkg;

    localparam int SECTOR_BYTES_DEF = 512;

    // Status register bits
    localparam logic [7:0] STS_BSY = 8'h80;
    localparam logic [7:0] STS_RDY = 8'h40;
    localparam logic [7:0] STS_DSC = 8'h10;
    localparam logic [7:0] STS_DRQ = 8'h08;
    localparam logic [7:0] STS_ERR = 8'h01;

    // Commands
    localparam logic [7:0] CMD_EXEC_DIAG  = 8'h90;
    localparam logic [7:0] CMD_SET_FEAT   = 8'hEF;
    localparam logic [7:0] CMD_READ       = 8'h20;
    localparam logic [7:0] CMD_READ_RETRY = 8'h21;
    localparam logic [7:0] CMD_IDENTIFY   = 8'hEC;

    localparam logic [7:0] FEAT_VALID  = 8'h01;
    localparam logic [7:0] DIAG_CODE   = 8'h01;
    localparam logic [7:0] BYTE_PAST_END = 8'hFF;
    localparam logic [7:0] COUNT_RESET = 8'h01;

    // Task file register offsets
    localparam logic [2:0] OFF_DATA  = 3'd0;
    localparam logic [2:0] OFF_ERROR = 3'd1;
    localparam logic [2:0] OFF_COUNT = 3'd2;
    localparam logic [2:0] OFF_LBA0  = 3'd3;
    localparam logic [2:0] OFF_LBA1  = 3'd4;
    localparam logic [2:0] OFF_LBA2  = 3'd5;
    localparam logic [2:0] OFF_LBA3  = 3'd6;
    localparam logic [2:0] OFF_CMD   = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_DISK0_PRESENT = 2'd0;
    localparam logic [1:0] CFG_DISK1_PRESENT = 2'd1;
    localparam logic [1:0] CFG_DISK0_BLOCKS  = 2'd2;
    localparam logic [1:0] CFG_DISK1_BLOCKS  = 2'd3;

    localparam int CFG_W   = 29;
    localparam int BLOCK_W = 28;
    localparam int DRIVE_BIT = 28;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_FILL  = 2'd2,
        MODE_IDLE  = 2'd3
    } tf_mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CLEAR
    } tf_state_t;

endpackage

>>> hdl/ide_task_file_controller.sv
// Top level of the IDE task file controller: register file, command decode, sector buffer.
//
// Usage. Drive mode, reg_offset, write_data and fill_index and raise start; the
// transaction is taken at a clock edge where start is high and busy is low.
// Mode 0 reads a task file register, mode 1 writes one (a write to offset 7 runs
// a command), mode 2 stores a byte from storage into the sector buffer.
// Each transaction yields one result: done is high for exactly one cycle, registered from
// the EXEC state after acceptance, with read_data, status_now and the fetch request.
// The result cannot be held off; capture it in the done cycle.
// A new transaction is taken only once the last is through: the buffer RAM read
// (registered output) comes first, then the EXEC state updates registers and writes
// the RAM. start may be high again in the done cycle.
// IDENTIFY zeroes the sector buffer with a sweep over every entry, one entry
// a cycle, during which busy stays high; configuration writes are still taken.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written only while idle; the block does not enforce this.
// Reset restores the task file registers (count 1, status RDY, read pointer at
// the buffer end); buffer contents are undefined until filled.
module ide_task_file_controller
    import ide_tf_pkg::*;
#(
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [2:0]         reg_offset,
    input  logic [7:0]         write_data,
    input  logic [8:0]         fill_index,
    output logic               done,
    output logic [7:0]         read_data,
    output logic [7:0]         status_now,
    output logic               fetch_request,
    output logic               fetch_drive,
    output logic [BLOCK_W-1:0] fetch_block,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data
);

    localparam int ADDR_W = $clog2(SECTOR_BYTES);
    localparam int PTR_W  = ADDR_W + 1;
    localparam logic [PTR_W-1:0] PTR_END = PTR_W'(SECTOR_BYTES);

    tf_state_t state_reg, state_next;

    tf_mode_t     item_mode_reg,  item_mode_next;
    logic [2:0]   item_off_reg,   item_off_next;
    logic [7:0]   item_wdata_reg, item_wdata_next;
    logic [8:0]   item_fidx_reg,  item_fidx_next;

    logic [PTR_W-1:0]  rp_reg, rp_next;
    logic [31:0]       lba_reg, lba_next;
    logic [7:0]        status_reg, status_next;
    logic [7:0]        error_reg, error_next;
    logic [7:0]        count_reg, count_next;
    logic [7:0]        feature_reg, feature_next;
    logic              d0p_reg, d0p_next;
    logic              d1p_reg, d1p_next;
    logic [CFG_W-1:0]  d0b_reg, d0b_next;
    logic [CFG_W-1:0]  d1b_reg, d1b_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;

    logic               done_reg, done_next;
    logic [7:0]         rdata_reg, rdata_next;
    logic [7:0]         ostat_reg, ostat_next;
    logic               freq_reg, freq_next;
    logic               fdrv_reg, fdrv_next;
    logic [BLOCK_W-1:0] fblk_reg, fblk_next;

    logic              accept;
    logic              is_identify;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    // Scratch values for command execution
    logic              dsc_eval;
    logic [CFG_W-1:0]  blk_ext;
    logic              sel_drv;
    logic              sel_present;
    logic [CFG_W-1:0]  sel_size;

    ide_tf_ram #(
        .WIDTH (8),
        .DEPTH (SECTOR_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign accept = start && (state_reg == S_IDLE);

    assign is_identify = (item_mode_reg == MODE_WRITE) && (item_off_reg == OFF_CMD)
                         && (item_wdata_reg == CMD_IDENTIFY);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = is_identify ? S_CLEAR : S_IDLE;
            end
            S_CLEAR:
            begin
                if (clr_cnt_reg == {ADDR_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs: handshake and buffer RAM port
    always_comb
    begin
        busy      = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = ADDR_W'(item_fidx_reg);
        mem_wdata = item_wdata_reg;
        mem_raddr = rp_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
            end
            S_EXEC:
            begin
                mem_we = (item_mode_reg == MODE_FILL);
            end
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Register file and command execution
    always_comb
    begin
        item_mode_next  = item_mode_reg;
        item_off_next   = item_off_reg;
        item_wdata_next = item_wdata_reg;
        item_fidx_next  = item_fidx_reg;
        rp_next         = rp_reg;
        lba_next        = lba_reg;
        status_next     = status_reg;
        error_next      = error_reg;
        count_next      = count_reg;
        feature_next    = feature_reg;
        d0p_next        = d0p_reg;
        d1p_next        = d1p_reg;
        d0b_next        = d0b_reg;
        d1b_next        = d1b_reg;
        clr_cnt_next    = clr_cnt_reg;
        done_next       = 1'b0;
        rdata_next      = rdata_reg;
        ostat_next      = ostat_reg;
        freq_next       = 1'b0;
        fdrv_next       = fdrv_reg;
        fblk_next       = fblk_reg;
        dsc_eval        = 1'b0;

        sel_drv     = lba_reg[DRIVE_BIT];
        sel_present = sel_drv ? d1p_reg : d0p_reg;
        sel_size    = sel_drv ? d1b_reg : d0b_reg;
        blk_ext     = {1'b0, lba_reg[BLOCK_W-1:0]};

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DISK0_PRESENT:
                begin
                    d0p_next = cfg_data[0];
                    dsc_eval = 1'b1;
                end
                CFG_DISK1_PRESENT:
                begin
                    d1p_next = cfg_data[0];
                    dsc_eval = 1'b1;
                end
                CFG_DISK0_BLOCKS: d0b_next = cfg_data;
                CFG_DISK1_BLOCKS: d1b_next = cfg_data;
                default:
                begin
                    dsc_eval = 1'b0;
                end
            endcase
            if (dsc_eval)
            begin
                status_next[4] = lba_reg[DRIVE_BIT] ? d1p_next : d0p_next;
            end
        end

        if (state_reg == S_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end

        if (state_reg == S_EXEC)
        begin
            done_next  = 1'b1;
            rdata_next = '0;
            freq_next  = 1'b0;
            fdrv_next  = 1'b0;
            fblk_next  = '0;
            unique case (item_mode_reg)
                MODE_READ:
                begin
                    unique case (item_off_reg)
                        OFF_DATA:
                        begin
                            if (rp_reg < PTR_END)
                            begin
                                rdata_next = mem_rdata;
                                rp_next    = rp_reg + 1'b1;
                                if (rp_next == PTR_END)
                                begin
                                    status_next = status_reg & ~STS_DRQ;
                                end
                            end
                            else
                            begin
                                rdata_next  = BYTE_PAST_END;
                                status_next = (status_reg | STS_ERR) & ~STS_DRQ;
                            end
                        end
                        OFF_ERROR: rdata_next = error_reg;
                        OFF_COUNT: rdata_next = count_reg;
                        OFF_LBA0:  rdata_next = lba_reg[7:0];
                        OFF_LBA1:  rdata_next = lba_reg[15:8];
                        OFF_LBA2:  rdata_next = lba_reg[23:16];
                        OFF_LBA3:  rdata_next = lba_reg[31:24];
                        default:   rdata_next = status_reg;
                    endcase
                end
                MODE_WRITE:
                begin
                    unique case (item_off_reg)
                        OFF_DATA:  rdata_next = '0;
                        OFF_ERROR: feature_next = item_wdata_reg;
                        OFF_COUNT: count_next = item_wdata_reg;
                        OFF_LBA0:  lba_next[7:0] = item_wdata_reg;
                        OFF_LBA1:  lba_next[15:8] = item_wdata_reg;
                        OFF_LBA2:  lba_next[23:16] = item_wdata_reg;
                        OFF_LBA3:
                        begin
                            lba_next[31:24] = item_wdata_reg;
                            // Re-evaluate seek complete when the drive bit flips
                            if (lba_next[DRIVE_BIT] != lba_reg[DRIVE_BIT])
                            begin
                                status_next[4] = lba_next[DRIVE_BIT] ? d1p_reg : d0p_reg;
                            end
                        end
                        default:
                        begin
                            unique case (item_wdata_reg) inside
                                CMD_EXEC_DIAG:
                                begin
                                    error_next = DIAG_CODE;
                                end
                                CMD_SET_FEAT:
                                begin
                                    if (feature_reg != FEAT_VALID)
                                    begin
                                        status_next = status_reg | STS_ERR;
                                    end
                                end
                                CMD_READ, CMD_READ_RETRY:
                                begin
                                    rp_next = '0;
                                    if (!sel_present || (count_reg != 8'd1)
                                        || (blk_ext >= sel_size))
                                    begin
                                        status_next = status_reg | STS_ERR;
                                    end
                                    else
                                    begin
                                        status_next = status_reg | STS_DRQ;
                                        freq_next   = 1'b1;
                                        fdrv_next   = sel_drv;
                                        fblk_next   = lba_reg[BLOCK_W-1:0];
                                    end
                                end
                                CMD_IDENTIFY:
                                begin
                                    rp_next     = '0;
                                    status_next = (status_reg & ~(STS_BSY | STS_ERR)) | STS_DRQ;
                                end
                                default:
                                begin
                                    status_next = STS_RDY | STS_ERR;
                                end
                            endcase
                        end
                    endcase
                end
                MODE_FILL:
                begin
                    rdata_next = '0;
                end
                default:
                begin
                    rdata_next = '0;
                end
            endcase
            ostat_next = status_next;
        end

        if (accept)
        begin
            item_mode_next  = tf_mode_t'(mode);
            item_off_next   = reg_offset;
            item_wdata_next = write_data;
            item_fidx_next  = fill_index;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rp_reg      <= PTR_END;
            lba_reg     <= '0;
            status_reg  <= STS_RDY;
            error_reg   <= '0;
            count_reg   <= COUNT_RESET;
            feature_reg <= '0;
            d0p_reg     <= 1'b0;
            d1p_reg     <= 1'b0;
            d0b_reg     <= '0;
            d1b_reg     <= '0;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rp_reg      <= rp_next;
            lba_reg     <= lba_next;
            status_reg  <= status_next;
            error_reg   <= error_next;
            count_reg   <= count_next;
            feature_reg <= feature_next;
            d0p_reg     <= d0p_next;
            d1p_reg     <= d1p_next;
            d0b_reg     <= d0b_next;
            d1b_reg     <= d1b_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    // Transaction and result payload
    always_ff @(posedge clk)
    begin
        item_mode_reg  <= item_mode_next;
        item_off_reg   <= item_off_next;
        item_wdata_reg <= item_wdata_next;
        item_fidx_reg  <= item_fidx_next;
        rdata_reg      <= rdata_next;
        ostat_reg      <= ostat_next;
        freq_reg       <= freq_next;
        fdrv_reg       <= fdrv_next;
        fblk_reg       <= fblk_next;
    end

    assign done          = done_reg;
    assign read_data     = rdata_reg;
    assign status_now    = ostat_reg;
    assign fetch_request = freq_reg;
    assign fetch_drive   = fdrv_reg;
    assign fetch_block   = fblk_reg;

endmodule

>>> hdl/ide_tf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ide_tf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/ide_tf_checker.sv
// Port-level checker for the IDE task file controller, bound to the top level.
`include "ide_task_file_controller_defines.svh"

module ide_tf_checker
    import ide_tf_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [7:0]         status_now,
    input logic               fetch_request,
    input logic               fetch_drive,
    input logic [BLOCK_W-1:0] fetch_block
);

    // Every accepted transaction is followed by its result
    `IDE_TF_ASSERT_LAT2(a_result_latency, start && !busy, done, "result missing after transaction")

    // Results never come in adjacent cycles
    `IDE_TF_ASSERT_NEXT(a_result_spacing, done, !done, "two results in adjacent cycles")

    // A fetch request only comes with a result and leaves DRQ set
    `IDE_TF_ASSERT_IMPL(a_fetch_drq, fetch_request, done && ((status_now & STS_DRQ) != 8'h00),
        "fetch request without result or DRQ")

    // Fetch fields are zero in a result that requests no block
    `IDE_TF_ASSERT_IMPL(a_fetch_zero, done && !fetch_request,
        !fetch_drive && (fetch_block == '0), "fetch fields set without request")

endmodule

bind ide_task_file_controller ide_tf_checker u_ide_tf_checker (.*);
